// ===== hdl/sjw_pkg.sv =====
package sjw_pkg;

	localparam int LINE_BYTES = 256;
	localparam int OFS_W = $clog2(LINE_BYTES);

	localparam logic [OFS_W-1:0] LAST_OFS = OFS_W'(LINE_BYTES - 1);
	localparam logic [OFS_W-1:0] PAIR_LAST_OFS = OFS_W'(LINE_BYTES - 3);
	localparam logic [7:0] COUNT_MAX = 8'hFF;

	localparam logic [7:0] CH_NUL = 8'h00;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_HASH = 8'h23;
	localparam logic [7:0] CH_SLASH = 8'h2F;

	typedef enum logic [1:0] {
		EV_WORD = 2'd0,
		EV_CUT = 2'd1,
		EV_END = 2'd2
	} event_kind_t;

	function automatic logic is_lead(input logic [7:0] c);
		return (c >= 8'h81 && c <= 8'h9F) || (c >= 8'hE0 && c <= 8'hEF);
	endfunction

	function automatic logic is_trail(input logic [7:0] c);
		return (c >= 8'h40 && c <= 8'h7E) || (c >= 8'h80 && c <= 8'hFC);
	endfunction

	function automatic logic is_letter(input logic [7:0] c);
		return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
	endfunction

	function automatic logic [7:0] to_pos(input logic [OFS_W-1:0] o);
		logic [OFS_W+7:0] w;
		w = {8'd0, o};
		return w[7:0];
	endfunction

endpackage

// ===== hdl/sjw_text_if.sv =====
interface sjw_text_if;
	logic valid;
	logic ready;
	logic [7:0] text_byte;
	logic line_start;

	modport source(output valid, text_byte, line_start, input ready);
	modport sink(input valid, text_byte, line_start, output ready);
endinterface

// ===== hdl/sjw_event_if.sv =====
interface sjw_event_if;
	logic valid;
	logic ready;
	logic [1:0] event_kind;
	logic [7:0] byte_position;
	logic [7:0] word_count;

	modport source(output valid, event_kind, byte_position, word_count, input ready);
	modport sink(input valid, event_kind, byte_position, word_count, output ready);
endinterface

// ===== hdl/sjis_word_splitter.sv =====
// Channel  Direction  Request contents
// text     in         text_byte, line_start
// events   out        event_kind, byte_position, word_count
//
// One request is taken per cycle when ready; any event it makes is registered next cycle.
// Each byte is decided when the following byte arrives, so events lag the input by one request.
// A request is taken while an event waits, provided the consumer takes it in the same cycle.
// Reset clears the held byte, the word flag, the line-done flag, the position and the count.
module sjis_word_splitter import sjw_pkg::*; (
	input logic clk,
	input logic arst_n,
	sjw_text_if.sink text,
	sjw_event_if.source events
);

	logic [7:0] held_q;
	logic held_valid_q;
	logic in_word_q;
	logic line_done_q;
	logic [OFS_W-1:0] offset_q;
	logic [7:0] count_q;

	logic out_valid_q;
	event_kind_t kind_q;
	logic [7:0] pos_q;
	logic [7:0] out_count_q;

	logic accept;
	logic load;

	logic [7:0] cur_held, nxt_held;
	logic cur_hv, nxt_hv;
	logic cur_in_word, nxt_in_word;
	logic cur_done, nxt_done;
	logic [OFS_W-1:0] cur_offset, nxt_offset;
	logic [7:0] cur_count, nxt_count;
	logic emit;
	event_kind_t kind;
	logic [7:0] b;

	assign text.ready = !out_valid_q || events.ready;
	assign accept = text.valid && text.ready;
	assign load = accept && emit;

	always_comb begin
		b = text.text_byte;
		if (text.line_start) begin
			cur_held = CH_NUL;
			cur_hv = 1'b0;
			cur_in_word = 1'b0;
			cur_done = 1'b0;
			cur_offset = '0;
			cur_count = 8'd0;
		end else begin
			cur_held = held_q;
			cur_hv = held_valid_q;
			cur_in_word = in_word_q;
			cur_done = line_done_q;
			cur_offset = offset_q;
			cur_count = count_q;
		end
		nxt_held = cur_held;
		nxt_hv = cur_hv;
		nxt_in_word = cur_in_word;
		nxt_done = cur_done;
		nxt_offset = cur_offset;
		nxt_count = cur_count;
		emit = 1'b0;
		kind = EV_WORD;
		if (!cur_done) begin
			if (!cur_hv) begin
				nxt_held = b;
				nxt_hv = 1'b1;
			end else if (cur_offset == LAST_OFS) begin
				nxt_done = 1'b1;
				emit = 1'b1;
				kind = EV_END;
			end else if (is_lead(cur_held) && is_trail(b) && cur_offset <= PAIR_LAST_OFS) begin
				if (!cur_in_word) begin
					nxt_in_word = 1'b1;
					nxt_count = (cur_count != COUNT_MAX) ? cur_count + 8'd1 : cur_count;
					emit = 1'b1;
					kind = EV_WORD;
				end
				nxt_offset = cur_offset + OFS_W'(2);
				nxt_hv = 1'b0;
				nxt_held = CH_NUL;
			end else if (cur_held == CH_NUL || cur_held == CH_LF || cur_held == CH_HASH ||
					(cur_held == CH_CR && b == CH_LF) ||
					(cur_held == CH_SLASH && b == CH_SLASH)) begin
				nxt_done = 1'b1;
				emit = 1'b1;
				kind = EV_END;
			end else begin
				if (cur_held == CH_SPACE || cur_held == CH_TAB) begin
					if (cur_in_word) begin
						emit = 1'b1;
						kind = EV_CUT;
					end
					nxt_in_word = 1'b0;
				end else if (is_letter(cur_held) && !cur_in_word) begin
					nxt_in_word = 1'b1;
					nxt_count = (cur_count != COUNT_MAX) ? cur_count + 8'd1 : cur_count;
					emit = 1'b1;
					kind = EV_WORD;
				end
				nxt_held = b;
				nxt_offset = cur_offset + OFS_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= CH_NUL;
			held_valid_q <= 1'b0;
			in_word_q <= 1'b0;
			line_done_q <= 1'b0;
			offset_q <= '0;
			count_q <= 8'd0;
		end else if (accept) begin
			held_q <= nxt_held;
			held_valid_q <= nxt_hv;
			in_word_q <= nxt_in_word;
			line_done_q <= nxt_done;
			offset_q <= nxt_offset;
			count_q <= nxt_count;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (events.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			kind_q <= kind;
			pos_q <= to_pos(cur_offset);
			out_count_q <= nxt_count;
		end
	end

	assign events.valid = out_valid_q;
	assign events.event_kind = kind_q;
	assign events.byte_position = pos_q;
	assign events.word_count = out_count_q;

	a_done_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && line_done_q && !text.line_start) |-> !load)
		else $error("event produced after the line had ended");

	a_first_byte_held: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (text.line_start || !held_valid_q) && !(line_done_q && !text.line_start))
		|-> !load)
		else $error("event produced without a held byte");

	a_offset_range: assert property (@(posedge clk) disable iff (!arst_n)
		offset_q <= LAST_OFS)
		else $error("byte offset beyond the line length");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> text.ready)
		else $error("input stalled with an empty output register");

	a_word_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !text.line_start && kind == EV_WORD && load && count_q != COUNT_MAX)
		|=> count_q == $past(count_q) + 8'd1)
		else $error("word event without a count increment");

	a_end_is_final: assert property (@(posedge clk) disable iff (!arst_n)
		(load && kind == EV_END) |=> line_done_q)
		else $error("line end event without the line-done flag");

endmodule
